/* rtl/clsr_pkg.sv */
// Shared types and constants for the combined LCG / shuffle-table generator.
// Holds generator constants, controller state encoding and the command and
// status bundles passed between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package clsr_pkg;

   // Generator word width and fixed arithmetic constants
   localparam int unsigned DATA_W      = 31;
   localparam int unsigned MOD1        = 32'd2147483563;
   localparam int unsigned MOD2        = 32'd2147483399;
   localparam int unsigned MUL1        = 32'd40014;
   localparam int unsigned MUL2        = 32'd40692;
   localparam int unsigned QUO1        = 32'd53668;
   localparam int unsigned QUO2        = 32'd52774;
   localparam int unsigned REM1        = 32'd12211;
   localparam int unsigned REM2        = 32'd3791;
   localparam int unsigned WRAP_TOP    = MOD1 - 32'd1;
   localparam int unsigned SECOND_INIT = 32'd123456789;

   // Schrage quotient/remainder width and reciprocal shift
   localparam int unsigned KQ_W        = 16;
   localparam int unsigned RECIP_SHIFT = 46;

   // Shuffle table size default and warm-up steps beyond the table fill
   localparam int unsigned TABLE_SIZE_DEF = 32;
   localparam int unsigned WARM_EXTRA     = 8;

   // Register file: one 31-bit seed register on a 32-bit bus, word index taken from paddr[2]
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic [0:0]  CSR_IDX_SEED = 1'b0;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_WARM_GO,
      ST_WARM_WAIT,
      ST_DRAW_GO,
      ST_DRAW_WAIT,
      ST_FINISH
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_seed;
      logic warm_start;
      logic warm_take;
      logic draw_start;
      logic draw_take;
      logic finish;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic warm_done;
      logic draw_done;
      logic cnt_zero;
      logic out_free;
   } dp_sts_type;

endpackage

/* rtl/clsr_schrage.sv */
// Five-stage Schrage step: returns (MUL * x) mod MOD without a wide product.
// Quotient x / QUO is found by reciprocal multiply plus one correction.
// Depends on clsr_pkg.
`timescale 1ns / 1ps

module clsr_schrage #(
   parameter int unsigned MUL = clsr_pkg::MUL1,
   parameter int unsigned QUO = clsr_pkg::QUO1,
   parameter int unsigned REM = clsr_pkg::REM1,
   parameter int unsigned MOD = clsr_pkg::MOD1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [clsr_pkg::DATA_W-1:0]  x,
   output logic                         done,
   output logic [clsr_pkg::DATA_W-1:0]  result
);
   import clsr_pkg::*;

   localparam int unsigned PW = 2 * DATA_W;
   localparam logic [DATA_W-1:0] Recip =
      DATA_W'((64'd1 << RECIP_SHIFT) / 64'(QUO));

   logic [4:0]          vld_ff, vld_in;
   logic [DATA_W-1:0]   x1_ff, x1_in;
   logic [PW-1:0]       p_ff, p_in;
   logic [DATA_W-1:0]   x2_ff, x2_in;
   logic [KQ_W-1:0]     k2_ff, k2_in;
   logic [31:0]         t2_ff, t2_in;
   logic [KQ_W-1:0]     k3_ff, k3_in;
   logic [KQ_W-1:0]     r3_ff, r3_in;
   logic [31:0]         ar_ff, ar_in;
   logic [31:0]         kr_ff, kr_in;
   logic [DATA_W-1:0]   res_ff, res_in;
   logic [31:0]         rem_raw;
   logic [32:0]         diff;
   logic [32:0]         diff_wrap;

   // Advance the stage valid bits
   assign vld_in = {vld_ff[3:0], start};

   always_comb begin
      // Stage 1: reciprocal product
      x1_in = x;
      p_in  = PW'(x) * PW'(Recip);
      // Stage 2: quotient estimate and its multiple of QUO
      x2_in = x1_ff;
      k2_in = p_ff[RECIP_SHIFT +: KQ_W];
      t2_in = 32'(k2_in) * 32'(QUO);
      // Stage 3: correct the estimate by one
      rem_raw = {1'b0, x2_ff} - t2_ff;
      if (rem_raw >= 32'(QUO)) begin
         k3_in = k2_ff + KQ_W'(1);
         r3_in = KQ_W'(rem_raw - 32'(QUO));
      end else begin
         k3_in = k2_ff;
         r3_in = KQ_W'(rem_raw);
      end
      // Stage 4: the two partial products
      ar_in = 32'(r3_ff) * 32'(MUL);
      kr_in = 32'(k3_ff) * 32'(REM);
      // Stage 5: subtract and fold a negative back by MOD
      diff      = {1'b0, ar_ff} - {1'b0, kr_ff};
      diff_wrap = diff + 33'(MOD);
      res_in    = diff[32] ? diff_wrap[DATA_W-1:0] : diff[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff  <= x1_in;
      p_ff   <= p_in;
      x2_ff  <= x2_in;
      k2_ff  <= k2_in;
      t2_ff  <= t2_in;
      k3_ff  <= k3_in;
      r3_ff  <= r3_in;
      ar_ff  <= ar_in;
      kr_ff  <= kr_in;
      res_ff <= res_in;
   end

   assign done   = vld_ff[4];
   assign result = res_ff;

endmodule

/* rtl/clsr_datapath.sv */
// Datapath: both generators, shuffle table memory, slot divider, warm-up
// counter and the result register. Driven by dp_cmd_type commands.
// Depends on clsr_pkg and clsr_schrage.
`timescale 1ns / 1ps

module clsr_datapath #(
   parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  clsr_pkg::dp_cmd_type         cmd,
   output clsr_pkg::dp_sts_type         sts,
   input  logic [clsr_pkg::DATA_W-1:0]  seed_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [clsr_pkg::DATA_W-1:0]  rsp_random_value
);
   import clsr_pkg::*;

   localparam int unsigned SW        = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int unsigned QW        = SW + 1;
   localparam int unsigned WarmSteps = TABLE_SIZE + WARM_EXTRA;
   localparam int unsigned CntW      = $clog2(WarmSteps);
   localparam int unsigned SlotShift = 56;
   localparam int unsigned ProdW     = 34;
   localparam logic [63:0] SlotDiv   = 64'd1 + 64'(WRAP_TOP) / 64'(TABLE_SIZE);
   localparam logic [31:0] SlotRecip = 32'((64'd1 << SlotShift) / SlotDiv);

   // Generator and sequencing state
   logic [DATA_W-1:0]   g1_ff, g1_in;
   logic [DATA_W-1:0]   g2_ff, g2_in;
   logic [DATA_W-1:0]   last_ff, last_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;

   // Slot divider pipeline
   logic [63:0]         sp_ff, sp_in;
   logic [QW-1:0]       sq_ff, sq_in;
   logic [ProdW-1:0]    sprod_ff, sprod_in;
   logic [QW-1:0]       sq_fix;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [SW-1:0]       slot_sel;
   logic [DATA_W-1:0]   rd_ff;
   logic                s1v_ff, s2v_ff;

   // Shuffle table
   logic [DATA_W-1:0]   table_mem [TABLE_SIZE];
   logic                tbl_we;
   logic [SW-1:0]       tbl_waddr;
   logic [DATA_W-1:0]   tbl_wdata;

   // Schrage units and misc
   logic                done1, done2;
   logic [DATA_W-1:0]   res1, res2;
   logic [DATA_W-1:0]   seed_wrap;
   logic [DATA_W-1:0]   seed_fix;
   logic [31:0]         y_diff;
   logic [31:0]         y_wrap;
   logic [DATA_W-1:0]   y_val;

   clsr_schrage #(
      .MUL (MUL1),
      .QUO (QUO1),
      .REM (REM1),
      .MOD (MOD1)
   ) u_sch1 (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.warm_start | cmd.draw_start),
      .x      (g1_ff),
      .done   (done1),
      .result (res1)
   );

   clsr_schrage #(
      .MUL (MUL2),
      .QUO (QUO2),
      .REM (REM2),
      .MOD (MOD2)
   ) u_sch2 (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.draw_start),
      .x      (g2_ff),
      .done   (done2),
      .result (res2)
   );

   // Reduce the seed once by MOD1 and map zero to one
   always_comb begin
      seed_wrap = (32'(seed_value) >= MOD1) ? DATA_W'(32'(seed_value) - MOD1) : seed_value;
      seed_fix  = (seed_wrap == '0) ? DATA_W'(1) : seed_wrap;
   end

   // Result: table value minus second generator, folded into 1..WRAP_TOP
   always_comb begin
      y_diff = {1'b0, rd_ff} - {1'b0, g2_ff};
      y_wrap = y_diff + WRAP_TOP;
      y_val  = ($signed(y_diff) < 32'sd1) ? y_wrap[DATA_W-1:0] : y_diff[DATA_W-1:0];
   end

   // Slot = last output / SlotDiv: reciprocal estimate, then one correction
   always_comb begin
      sp_in    = 64'(last_ff) * 64'(SlotRecip);
      sq_in    = sp_ff[SlotShift +: QW];
      sprod_in = ProdW'(sq_in + QW'(1)) * ProdW'(SlotDiv);
      sq_fix   = (ProdW'(last_ff) >= sprod_ff) ? sq_ff + QW'(1) : sq_ff;
      slot_sel = (32'(sq_fix) >= TABLE_SIZE) ? SW'(TABLE_SIZE - 1) : SW'(sq_fix);
      slot_in  = s2v_ff ? slot_sel : slot_ff;
   end

   // Generator, counter and output register next values
   always_comb begin
      g1_in        = g1_ff;
      g2_in        = g2_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = slot_ff;
      tbl_wdata    = g1_ff;
      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_seed) begin
         g1_in  = seed_fix;
         g2_in  = seed_fix;
         cnt_in = CntW'(WarmSteps - 1);
      end
      if (cmd.warm_take) begin
         g1_in = res1;
         if (32'(cnt_ff) < TABLE_SIZE) begin
            tbl_we    = 1'b1;
            tbl_waddr = SW'(cnt_ff);
            tbl_wdata = res1;
         end
         if (cnt_ff == '0) begin
            last_in = res1;
         end else begin
            cnt_in = cnt_ff - CntW'(1);
         end
      end
      if (cmd.draw_take) begin
         g1_in = res1;
         g2_in = res2;
      end
      if (cmd.finish) begin
         tbl_we       = 1'b1;
         last_in      = y_val;
         rsp_valid_in = 1'b1;
         rsp_value_in = y_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_ff        <= DATA_W'(1);
         g2_ff        <= DATA_W'(SECOND_INIT);
         last_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         s1v_ff       <= 1'b0;
         s2v_ff       <= 1'b0;
      end else begin
         g1_ff        <= g1_in;
         g2_ff        <= g2_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         s1v_ff       <= cmd.draw_start;
         s2v_ff       <= s1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff        <= sp_in;
      sq_ff        <= sq_in;
      sprod_ff     <= sprod_in;
      slot_ff      <= slot_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Table: one write port, registered read at the corrected slot
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
      if (s2v_ff) begin
         rd_ff <= table_mem[slot_sel];
      end
   end

   always_comb begin
      sts.warm_done = done1;
      sts.draw_done = done1 & done2;
      sts.cnt_zero  = (cnt_ff == '0);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule

/* rtl/clsr_ctrl.sv */
// Controller state machine: request accept, seeding and warm-up sequence,
// draw sequencing and hand-off to the result register.
// Depends on clsr_pkg.
`timescale 1ns / 1ps

module clsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_reseed,
   output clsr_pkg::dp_cmd_type  cmd,
   input  clsr_pkg::dp_sts_type  sts
);
   import clsr_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           seeded_ff, seeded_in;
   logic           accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_reseed || !seeded_ff) ? ST_SEED : ST_DRAW_GO;
            end
         end
         ST_SEED:      state_in = ST_WARM_GO;
         ST_WARM_GO:   state_in = ST_WARM_WAIT;
         ST_WARM_WAIT: begin
            if (sts.warm_done) begin
               state_in = sts.cnt_zero ? ST_DRAW_GO : ST_WARM_GO;
            end
         end
         ST_DRAW_GO:   state_in = ST_DRAW_WAIT;
         ST_DRAW_WAIT: begin
            if (sts.draw_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE:      req_stall      = 1'b0;
         ST_SEED:      cmd.load_seed  = 1'b1;
         ST_WARM_GO:   cmd.warm_start = 1'b1;
         ST_WARM_WAIT: cmd.warm_take  = sts.warm_done;
         ST_DRAW_GO:   cmd.draw_start = 1'b1;
         ST_DRAW_WAIT: cmd.draw_take  = sts.draw_done;
         ST_FINISH:    cmd.finish     = sts.out_free;
         default:      req_stall      = 1'b1;
      endcase
   end

   // Mark seeded once the last warm-up step lands
   assign seeded_in = seeded_ff | (cmd.warm_take & sts.cnt_zero);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seeded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

/* rtl/combined_lcg_shuffle_rng_core.sv */
// Top level of the combined LCG generator with shuffle table: register port,
// seed register, controller and datapath.
// Depends on clsr_pkg, clsr_ctrl and clsr_datapath.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                   Payload
//  req_      in         req_valid / req_stall       req_reseed
//  rsp_      out        rsp_valid / rsp_stall       rsp_random_value
//  csr_      in/out     csr_psel/penable/pready     paddr, pwdata, prdata
//
//  A plain draw runs from accept through the launch state, one step of the
//  five-stage Schrage units and the finish state.
//  A reseed, or the first draw after reset, adds the seed state and a serial
//  warm-up through one unit, one step per table entry plus WARM_EXTRA more.
//  Synchronous reset clears control state; table contents start undefined.
//  A result waits in the output register while rsp_stall is high; the next
//  request is accepted meanwhile and held in its finish state until it drains.

module combined_lcg_shuffle_rng_core #(
   parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_reseed,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [clsr_pkg::DATA_W-1:0]      rsp_random_value,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [clsr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [clsr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [clsr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import clsr_pkg::*;

   logic [DATA_W-1:0] seed_ff, seed_in;
   logic              csr_wr;
   dp_cmd_type        cmd;
   dp_sts_type        sts;

   // Register port: always ready, single seed register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_IDX_SEED);
   assign seed_in    = csr_wr ? csr_pwdata[DATA_W-1:0] : seed_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SEED) ? CSR_DATA_W'(seed_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= DATA_W'(1);
      end else begin
         seed_ff <= seed_in;
      end
   end

   clsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_reseed (req_reseed),
      .cmd        (cmd),
      .sts        (sts)
   );

   clsr_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .seed_value       (seed_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

endmodule
